>>> sv/ogru_pkg.sv
// Package for the occupancy grid ray update block: map limits, payload
// structs, cell codes and register addresses. No dependencies.
package ogru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    localparam int COORD_W = 12;                 // signed coordinate fields
    localparam int CFG_W   = 11;                 // grid_width / grid_height
    localparam int CELL_W  = 8;                  // signed cell value
    localparam int CNT_W   = 10;                 // free_cells_marked
    localparam int EXT_W   = COORD_W + 1;        // unsigned map compares
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ERR_W   = ((XW > YW) ? XW : YW) + 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index is paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1024);

    localparam logic FUNC_RAY  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic signed [CELL_W-1:0] CELL_UNKNOWN  = -8'sd1;
    localparam logic signed [CELL_W-1:0] CELL_FREE     = 8'sd0;
    localparam logic signed [CELL_W-1:0] CELL_OCCUPIED = 8'sd100;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // cells hold only three values, stored as 2-bit codes
    typedef enum logic [1:0] {
        CODE_UNKNOWN = 2'd0,
        CODE_FREE    = 2'd1,
        CODE_OCC     = 2'd2
    } cell_code_t;

    typedef struct packed {
        logic                      func;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
    } req_t;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic                     out_of_bounds;
        logic [CNT_W-1:0]         free_cells_marked;
    } rsp_t;

    function automatic logic signed [CELL_W-1:0] code_value(input logic [1:0] code);
        logic signed [CELL_W-1:0] v;
        unique case (code)
            CODE_FREE: v = CELL_FREE;
            CODE_OCC:  v = CELL_OCCUPIED;
            default:   v = CELL_UNKNOWN;
        endcase
        return v;
    endfunction

endpackage

>>> sv/occupancy_grid_ray_update.sv
// Occupancy grid ray update: grid memory, Bresenham walker, APB registers.
// Depends on ogru_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  req      | in        | req_valid/req_stall| ogru_pkg::req_t (ray or read)
//  rsp      | out       | rsp_valid/rsp_stall| ogru_pkg::rsp_t (one per req)
//  apb      | in/out    | psel/penable/pready| grid_width @0x0, grid_height @0x4
//
// Requests are handled one at a time; a ray walks n = max(|dx|, |dy|) <= 1023
// cells, one cell freed per cycle. Off-map items skip the grid.
// Reset: all DEPTH (1,048,576) cells are swept to unknown, one cell a cycle,
// with req_stall high; APB writes are taken at any time.
// Stalls: a finished response waits in the output register while the next
// request is accepted; a second one holds the block in the RESP state.
module occupancy_grid_ray_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ogru_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output ogru_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ogru_pkg::APB_AW-1:0]   paddr,
    input  logic [ogru_pkg::APB_DW-1:0]   pwdata,
    output logic [ogru_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import ogru_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,    // bounds check, ray setup, grid read issue
        S_READ,    // grid read data back
        S_MARK,    // hit cell -> occupied
        S_WALK,    // one free cell per cycle
        S_RESP     // hand result to output register
    } state_t;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic             apb_write;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= WIDTH_RESET;
            grid_height_reg <= HEIGHT_RESET;
        end
        else if (apb_write)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                grid_width_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                grid_height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WIDTH) ? APB_DW'(grid_width_reg)
                                            : APB_DW'(grid_height_reg);

    // effective map size saturates at the maximum
    logic [EXT_W-1:0] eff_w, eff_h;
    assign eff_w = (int'(grid_width_reg) > MAX_WIDTH)   ? EXT_W'(MAX_WIDTH)
                                                        : EXT_W'(grid_width_reg);
    assign eff_h = (int'(grid_height_reg) > MAX_HEIGHT) ? EXT_W'(MAX_HEIGHT)
                                                        : EXT_W'(grid_height_reg);

    function automatic logic in_map(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic [EXT_W-1:0] w,
                                    input logic [EXT_W-1:0] h);
        logic ok;
        ok = !x[COORD_W-1] && !y[COORD_W-1]
             && ({1'b0, x} < w) && ({1'b0, y} < h);
        return ok;
    endfunction

    // ---------------- control and datapath registers ----------------
    state_t                   state_reg, state_next;
    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;
    req_t                     req_reg, req_next;
    logic [XW-1:0]            x_reg, x_next, xe_reg, xe_next, dx_reg, dx_next;
    logic [YW-1:0]            y_reg, y_next, ye_reg, ye_next, dy_reg, dy_next;
    logic                     negx_reg, negx_next, negy_reg, negy_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    rsp_t                     res_reg, res_next;
    rsp_t                     rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    // ---------------- grid memory ----------------
    logic [1:0]        mem [DEPTH];
    logic [1:0]        rd_code_reg;
    logic              mem_we, mem_re;
    logic [1:0]        mem_code;
    logic [ADDR_W-1:0] mem_addr, cell_addr;
    logic [XW-1:0]     ax;
    logic [YW-1:0]     ay;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_code;
        end
        if (mem_re)
        begin
            rd_code_reg <= mem[mem_addr];
        end
    end

    // fixed row stride of MAX_WIDTH, independent of the configured width
    assign cell_addr = ADDR_W'(ADDR_W'(ay) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ax));
    assign mem_addr  = (state_reg == S_CLEAR) ? clr_addr_reg : cell_addr;

    // ---------------- walker arithmetic ----------------
    logic                    start_ok, end_ok, query_ok, at_end, step_x, step_y;
    logic signed [ERR_W:0]   e2, dx_s, dy_s;
    logic [XW-1:0]           sxu, exu;
    logic [YW-1:0]           syu, eyu;

    assign start_ok = in_map(req_reg.start_x, req_reg.start_y, eff_w, eff_h);
    assign end_ok   = in_map(req_reg.end_x, req_reg.end_y, eff_w, eff_h);
    assign query_ok = in_map(req_reg.query_x, req_reg.query_y, eff_w, eff_h);

    assign sxu = req_reg.start_x[XW-1:0];
    assign syu = req_reg.start_y[YW-1:0];
    assign exu = req_reg.end_x[XW-1:0];
    assign eyu = req_reg.end_y[YW-1:0];

    assign at_end = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign e2     = {err_reg, 1'b0};
    assign dx_s   = (ERR_W+1)'(dx_reg);
    assign dy_s   = (ERR_W+1)'(dy_reg);
    assign step_x = (e2 >= -dy_s);
    assign step_y = (e2 <= dx_s);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        req_next       = req_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xe_next        = xe_reg;
        ye_next        = ye_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_code       = CODE_UNKNOWN;
        ax             = x_reg;
        ay             = y_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ax = req_reg.query_x[XW-1:0];
                ay = req_reg.query_y[YW-1:0];
                res_next.cell_value        = CELL_FREE;
                res_next.out_of_bounds     = 1'b0;
                res_next.free_cells_marked = '0;
                if (req_reg.func == FUNC_READ)
                begin
                    if (query_ok)
                    begin
                        mem_re     = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        res_next.cell_value    = CELL_UNKNOWN;
                        res_next.out_of_bounds = 1'b1;
                        state_next             = S_RESP;
                    end
                end
                else if (start_ok && end_ok)
                begin
                    x_next     = sxu;
                    y_next     = syu;
                    xe_next    = exu;
                    ye_next    = eyu;
                    dx_next    = (exu > sxu) ? exu - sxu : sxu - exu;
                    dy_next    = (eyu > syu) ? eyu - syu : syu - eyu;
                    negx_next  = !(sxu < exu);
                    negy_next  = !(syu < eyu);
                    state_next = S_MARK;
                end
                else
                begin
                    res_next.out_of_bounds = 1'b1;
                    state_next             = S_RESP;
                end
            end
            S_READ:
            begin
                res_next.cell_value = code_value(rd_code_reg);
                state_next          = S_RESP;
            end
            S_MARK:
            begin
                ax         = xe_reg;
                ay         = ye_reg;
                mem_we     = 1'b1;
                mem_code   = CODE_OCC;
                err_next   = ERR_W'(ERR_W'(dx_reg) - ERR_W'(dy_reg));
                cnt_next   = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (at_end)
                begin
                    res_next.free_cells_marked = cnt_reg;
                    state_next                 = S_RESP;
                end
                else
                begin
                    mem_we   = 1'b1;
                    mem_code = CODE_FREE;
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    err_next = ERR_W'(err_reg
                                      - (step_x ? ERR_W'(dy_reg) : ERR_W'(0))
                                      + (step_y ? ERR_W'(dx_reg) : ERR_W'(0)));
                    if (step_x)
                    begin
                        x_next = negx_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                    end
                    if (step_y)
                    begin
                        y_next = negy_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            req_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            xe_reg        <= '0;
            ye_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            negx_reg      <= 1'b0;
            negy_reg      <= 1'b0;
            err_reg       <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            req_reg       <= req_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            xe_reg        <= xe_next;
            ye_reg        <= ye_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            negx_reg      <= negx_next;
            negy_reg      <= negy_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
        end
    end

    // ---------------- assertions ----------------
    // walker never leaves the configured map
    a_walk_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> ((EXT_W'(x_reg) < eff_w) && (EXT_W'(y_reg) < eff_h)))
        else $error("ray walk left the map");

    // single-port grid: no read and write together
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("grid read and write in the same cycle");

    // a response only appears out of the RESP state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response without a finished transaction");

    // the hit cell is written occupied and the walk follows
    a_mark_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (mem_we && (mem_code == CODE_OCC)) ##1 (state_reg == S_WALK))
        else $error("hit cell not marked before walk");

endmodule

>>> tb/tb_occupancy_grid_ray_update.sv
// Testbench for occupancy_grid_ray_update: drives ray and read transactions,
// predicts each response from its own grid model and checks it field by field.
// Depends on ogru_pkg and the occupancy_grid_ray_update RTL.
`timescale 1ns / 1ps

module tb_occupancy_grid_ray_update;
    import ogru_pkg::*;

    // ------------------------------------------------------------------
    // DUT signals. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_t                req       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // register byte addresses: index i sits at 4*i, index bit is paddr[2]
    localparam logic [APB_AW-1:0] ADDR_GRID_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_GRID_HEIGHT = {REG_HEIGHT, 2'b00};

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    int   send_idle_pct = 0;        // chance the sender inserts a bubble
    int   recv_idle_pct = 0;        // chance the receiver stalls a cycle
    bit   hold_on       = 1'b0;     // long receiver hold-off in progress
    int   err_count     = 0;

    // Grid model: only cells written since reset are stored; anything absent
    // reads back as unknown, which matches the cleared map after reset.
    logic signed [CELL_W-1:0] grid_model [int];
    logic [CFG_W-1:0]         map_cols_cfg = WIDTH_RESET;
    logic [CFG_W-1:0]         map_rows_cfg = HEIGHT_RESET;
    rsp_t                     expected_rsp_q [$];

    int rays_sent    = 0;
    int reads_sent   = 0;
    int off_map_seen = 0;
    int rsp_checked  = 0;

    occupancy_grid_ray_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------
    // Map size in use; register values above the maximum clamp to it.
    function automatic int eff_cols();
        return (map_cols_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(map_cols_cfg);
    endfunction

    function automatic int eff_rows();
        return (map_rows_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(map_rows_cfg);
    endfunction

    function automatic bit on_map(input int x, input int y);
        return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
    endfunction

    // cells use a fixed stride, so resizing the map never moves them
    function automatic int cell_key(input int x, input int y);
        return y * MAX_WIDTH + x;
    endfunction

    // Applies one transaction to the grid model and returns its response.
    function automatic rsp_t predict_response(input req_t t);
        rsp_t r;
        int   x0, y0, x1, y1;
        int   dx, dy, sx, sy, err, e2, n;
        r = '0;
        r.cell_value = CELL_FREE;
        if (t.func == FUNC_RAY)
        begin
            rays_sent++;
            x0 = t.start_x;
            y0 = t.start_y;
            x1 = t.end_x;
            y1 = t.end_y;
            if (on_map(x0, y0) && on_map(x1, y1))
            begin
                grid_model[cell_key(x1, y1)] = CELL_OCCUPIED;
                // Bresenham walk, stops one cell short of the hit
                dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
                dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
                sx  = (x0 < x1) ? 1 : -1;
                sy  = (y0 < y1) ? 1 : -1;
                err = dx + dy;
                n   = 0;
                while (!(x0 == x1 && y0 == y1))
                begin
                    e2 = 2 * err;
                    if (on_map(x0, y0))
                        grid_model[cell_key(x0, y0)] = CELL_FREE;
                    n++;
                    if (e2 >= dy)
                    begin
                        err += dy;
                        x0  += sx;
                    end
                    if (e2 <= dx)
                    begin
                        err += dx;
                        y0  += sy;
                    end
                end
                r.free_cells_marked = (n > CNT_MAX) ? CNT_MAX : CNT_W'(n);
            end
            else
            begin
                r.out_of_bounds = 1'b1;
                off_map_seen++;
            end
        end
        else
        begin
            reads_sent++;
            x0 = t.query_x;
            y0 = t.query_y;
            if (on_map(x0, y0))
                r.cell_value = grid_model.exists(cell_key(x0, y0)) ?
                               grid_model[cell_key(x0, y0)] : CELL_UNKNOWN;
            else
            begin
                r.cell_value    = CELL_UNKNOWN;
                r.out_of_bounds = 1'b1;
                off_map_seen++;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; printing is capped, counting is not
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= 40)
            $display("[%0t] mismatch: %s, got %0d, want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. The response side is
    // checked before the request side is predicted; a response can never
    // belong to a transaction accepted at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("response with nothing outstanding", rsp.cell_value, 0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    rsp_checked++;
                    if (rsp.cell_value !== want.cell_value)
                        report_mismatch("cell_value", rsp.cell_value, want.cell_value);
                    if (rsp.out_of_bounds !== want.out_of_bounds)
                        report_mismatch("out_of_bounds", rsp.out_of_bounds,
                                        want.out_of_bounds);
                    if (rsp.free_cells_marked !== want.free_cells_marked)
                        report_mismatch("free_cells_marked", rsp.free_cells_marked,
                                        want.free_cells_marked);
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_response(req));
        end
    end

    // Receiver: random stalls at the falling edge, forced high while a long
    // hold-off runs.
    always @(negedge clk)
        rsp_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] to_coord(input int v);
        if (v < -2048)
            v = -2048;
        else if (v > 2047)
            v = 2047;
        return COORD_W'(v);
    endfunction

    // Unused fields carry random bits so that they are seen to be ignored.
    function automatic req_t ray_item(input int sx, input int sy, input int ex, input int ey);
        req_t t;
        t = req_t'({$urandom, $urandom, $urandom} >> (96 - $bits(req_t)));
        t.func    = FUNC_RAY;
        t.start_x = to_coord(sx);
        t.start_y = to_coord(sy);
        t.end_x   = to_coord(ex);
        t.end_y   = to_coord(ey);
        return t;
    endfunction

    function automatic req_t read_item(input int qx, input int qy);
        req_t t;
        t = req_t'({$urandom, $urandom, $urandom} >> (96 - $bits(req_t)));
        t.func    = FUNC_READ;
        t.query_x = to_coord(qx);
        t.query_y = to_coord(qy);
        return t;
    endfunction

    // Mostly well-formed traffic in a small window near the origin, so reads
    // land on cells that rays have touched; some long rays, some noise.
    function automatic req_t random_transaction();
        req_t t;
        int   cols, rows, win_x, win_y, sx, sy;
        t = req_t'({$urandom, $urandom, $urandom} >> (96 - $bits(req_t)));
        t.func = ($urandom_range(99) < 45) ? FUNC_READ : FUNC_RAY;
        // noise: full-range coordinates, nearly always off the map
        if ($urandom_range(99) < 10)
            return t;
        cols  = eff_cols();
        rows  = eff_rows();
        win_x = (cols > 48) ? 48 : ((cols < 1) ? 1 : cols);
        win_y = (rows > 48) ? 48 : ((rows < 1) ? 1 : rows);
        if (t.func == FUNC_READ)
        begin
            // one cell past each edge of the window is included
            t.query_x = to_coord(int'($urandom_range(win_x + 1)) - 1);
            t.query_y = to_coord(int'($urandom_range(win_y + 1)) - 1);
        end
        else
        begin
            sx = $urandom_range(win_x - 1);
            sy = $urandom_range(win_y - 1);
            t.start_x = to_coord(sx);
            t.start_y = to_coord(sy);
            if ($urandom_range(39) == 0 && cols > 0 && rows > 0)
            begin
                // long ray to anywhere on the map
                t.end_x = to_coord($urandom_range(cols - 1));
                t.end_y = to_coord($urandom_range(rows - 1));
            end
            else
            begin
                t.end_x = to_coord(sx + int'($urandom_range(24)) - 12);
                t.end_y = to_coord(sy + int'($urandom_range(24)) - 12);
            end
        end
        return t;
    endfunction

    // Offers one transaction, entered and left at a falling edge. Bubbles come
    // before the offer; once offered, the payload holds until accepted.
    task automatic send_transaction(input req_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= t;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender goes quiet until every outstanding response has come back.
    task automatic wait_for_responses();
        int spins;
        spins = 0;
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0 && spins < 400000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // APB transfers: setup then access, then idle. Entered and
    // left at a falling edge with no assignment pending.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Resizes the map while idle. Bits above the 11-bit register get junk,
    // which the block must drop; both registers are read back.
    task automatic set_map_size(input int cols, input int rows);
        logic [APB_DW-1:0] rd;
        wait_for_responses();
        apb_write(ADDR_GRID_WIDTH, ($urandom << CFG_W) | APB_DW'(cols));
        map_cols_cfg = CFG_W'(cols);
        apb_write(ADDR_GRID_HEIGHT, ($urandom << CFG_W) | APB_DW'(rows));
        map_rows_cfg = CFG_W'(rows);
        apb_read(ADDR_GRID_WIDTH, rd);
        if (rd !== APB_DW'(map_cols_cfg))
            report_mismatch("grid_width readback", rd, map_cols_cfg);
        apb_read(ADDR_GRID_HEIGHT, rd);
        if (rd !== APB_DW'(map_rows_cfg))
            report_mismatch("grid_height readback", rd, map_rows_cfg);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Fresh map reads unknown everywhere; coordinate extremes are off the map.
    task automatic test_reset_map();
        send_transaction(read_item(0, 0));
        send_transaction(read_item(1023, 1023));
        send_transaction(read_item(-2048, -2048));
        send_transaction(read_item(2047, 2047));
        send_transaction(read_item(1024, 0));
    endtask

    // Line shapes in several octants, a point ray, a full-width ray and rays
    // with one end just outside, then reads of cells they touched.
    task automatic test_ray_shapes();
        send_transaction(ray_item(10, 10, 10, 10));   // ends coincide
        send_transaction(ray_item(2, 3, 9, 3));       // horizontal
        send_transaction(ray_item(4, 9, 4, 1));       // vertical, upward
        send_transaction(ray_item(0, 0, 7, 3));       // shallow
        send_transaction(ray_item(20, 20, 17, 9));    // steep, both steps negative
        send_transaction(ray_item(0, 0, 1023, 511));  // full-width ray, the most cells a walk can free
        send_transaction(ray_item(-1, 5, 5, 5));      // sensor off the map
        send_transaction(ray_item(6, 6, 6, 1024));    // hit off the map
        send_transaction(read_item(10, 10));
        send_transaction(read_item(5, 3));
        send_transaction(read_item(4, 1));
        send_transaction(read_item(1023, 511));
    endtask

    // Zero size, sizes above the maximum and one-cell-wide maps.
    task automatic test_map_size_edges();
        set_map_size(0, 1024);
        send_transaction(read_item(0, 0));
        send_transaction(ray_item(0, 0, 1, 1));
        set_map_size(2047, 1);
        send_transaction(ray_item(0, 0, 1023, 0));    // count reaches its maximum
        send_transaction(read_item(0, 1));
        set_map_size(1, 2047);
        send_transaction(ray_item(0, 1023, 0, 0));
        send_transaction(read_item(1, 0));
        set_map_size(0, 0);
        send_transaction(read_item(0, 0));
        set_map_size(1024, 1024);
        send_transaction(read_item(1023, 0));
    endtask

    // Receiver holds off while the sender keeps offering, so
    // the output register and the response state fill and req_stall rises.
    task automatic test_stalled_output();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_on = 1'b1;
                repeat (300) @(posedge clk);
                hold_on = 1'b0;
            end
        join_none
        repeat (14) send_transaction(random_transaction());
        wait_for_responses();
        send_idle_pct = saved_pct;
    endtask

    // Random traffic in chunks, each with its own map size.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int chunks);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (chunks)
        begin
            case ($urandom_range(6))
                0: set_map_size(1024, 1024);
                1: set_map_size(2047, $urandom_range(1, 64));   // width saturates
                2: set_map_size($urandom_range(1, 64), $urandom_range(1, 64));
                3: set_map_size(1, $urandom_range(1, 2047));
                4: set_map_size($urandom_range(1, 2047), 1);
                5: set_map_size($urandom_range(65, 1024), $urandom_range(65, 1024));
                default: set_map_size(0, $urandom_range(0, 2047));
            endcase
            repeat (48) send_transaction(random_transaction());
        end
    endtask

    // ------------------------------------------------------------------
    // Run order
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        // the block sweeps the grid after reset; req_stall covers it

        test_reset_map();
        test_ray_shapes();
        test_map_size_edges();

        test_random_traffic(28, 70, 4);
        test_stalled_output();
        test_random_traffic(70, 28, 4);
        test_random_traffic(0, 0, 4);

        wait_for_responses();
        if (expected_rsp_q.size() != 0)
            report_mismatch("responses never arrived", expected_rsp_q.size(), 0);

        $display("run covered %0d ray and %0d read transactions, %0d off the map",
                 rays_sent, reads_sent, off_map_seen);
        $display("%0d responses checked across sizes from empty to saturated maps",
                 rsp_checked);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: the post-reset sweep alone is about 8.4 ms of sim time.
    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
